// ===== hdl/spq_pkg.sv =====
package spq_pkg;

   localparam int unsigned KeyW   = 32;
   localparam int unsigned StatW  = 2;
   localparam int unsigned CountW = 5;

   typedef logic signed [KeyW-1:0] key_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [StatW-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Command broadcast to every cell in the chain.
   typedef struct packed {
      logic    ins;
      logic    rem;
      key_type key;
   } cmd_type;

   // What one cell shows to its neighbors.
   typedef struct packed {
      logic    gt;
      logic    occ;
      key_type value;
   } link_type;

endpackage

// ===== hdl/spq_req_if.sv =====
interface spq_req_if;
   logic              valid;
   logic              ready;
   spq_pkg::op_type   req_type;
   spq_pkg::key_type  key_value;

   modport source (output valid, output req_type, output key_value, input ready);
   modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

// ===== hdl/spq_rsp_if.sv =====
interface spq_rsp_if;
   logic                               valid;
   logic                               ready;
   spq_pkg::key_type                   removed_value;
   spq_pkg::status_type                status;
   logic [spq_pkg::CountW-1:0]         entry_count;

   modport source (output valid, output removed_value, output status, output entry_count,
                   input ready);
   modport sink   (input valid, input removed_value, input status, input entry_count,
                   output ready);
endinterface

// ===== hdl/spq_cell.sv =====
module spq_cell (
   input  logic              clock,
   input  spq_pkg::cmd_type  cmd,
   input  logic              occ,
   input  spq_pkg::link_type left,
   input  spq_pkg::key_type  right_value,
   output spq_pkg::link_type link
);

   spq_pkg::key_type value_ff;
   spq_pkg::key_type value_in;
   logic             gt;
   logic             tail;

   // The new key sorts strictly before this entry, so the entry moves up.
   assign gt   = occ && (cmd.key < value_ff);
   // First empty slot: the store grows into this cell.
   assign tail = !occ && left.occ;

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (left.gt) begin
            value_in = left.value;
         end else if (gt || tail) begin
            value_in = cmd.key;
         end
      end else if (cmd.rem) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link.gt    = gt;
   assign link.occ   = occ;
   assign link.value = value_ff;

endmodule

// ===== hdl/sorted_priority_queue_core.sv =====
// Ascending priority queue of signed 32-bit keys, held sorted in a row of
// DEPTH cells. A request either inserts req_type = insert with key_value, or
// removes the smallest key. Each request gets exactly one response, in the cycle
// after it is accepted, carrying the removed key (zero unless a remove
// succeeded), a status of done, full or empty, and the entry count after the
// request. Equal keys leave in the order in which they arrived. The block
// takes one request per cycle while responses are taken: every cell compares
// the incoming key with its own entry and its left neighbor's decision in the
// same cycle, so an insert or a remove costs the same no matter how full the
// store is. A new request is accepted whenever the response register is
// empty or its response is taken in the same cycle. The store needs no
// clearing; reset clears only the entry count and the response valid flag.
module sorted_priority_queue_core #(
   parameter int unsigned DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_ch,
   spq_rsp_if.source  rsp_ch
);

   localparam int unsigned CntW = $clog2(DEPTH + 1);

   logic [CntW-1:0]     count_ff;
   logic [CntW-1:0]     count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   spq_pkg::key_type    removed_ff;
   spq_pkg::key_type    removed_in;
   spq_pkg::status_type status_ff;
   spq_pkg::status_type status_in;

   logic                accept;
   logic                full;
   logic                empty;
   spq_pkg::cmd_type    cmd;
   spq_pkg::link_type   links [DEPTH];

   // The response register frees up when it is empty or being drained.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign full  = (count_ff == CntW'(DEPTH));
   assign empty = (count_ff == '0);

   // Refused requests never reach the cells, so the store stays untouched.
   assign cmd.ins = accept && (req_ch.req_type == spq_pkg::OP_INSERT) && !full;
   assign cmd.rem = accept && (req_ch.req_type == spq_pkg::OP_REMOVE) && !empty;
   assign cmd.key = req_ch.key_value;

   // Cell i is occupied when i lies below the count. The leftmost cell sees
   // an occupied, never-greater neighbor so that it becomes the tail of an
   // empty store.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::link_type left;
      spq_pkg::key_type  right_value;

      if (i == 0) begin : g_first
         assign left.gt    = 1'b0;
         assign left.occ   = 1'b1;
         assign left.value = '0;
      end else begin : g_inner
         assign left = links[i-1];
      end

      // Nothing shifts into the last cell; it simply drops out of the count.
      if (i == DEPTH - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_mid
         assign right_value = links[i+1].value;
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occ         (CntW'(i) < count_ff),
         .left        (left),
         .right_value (right_value),
         .link        (links[i])
      );
   end

   // Count update and the response for the request being accepted.
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         removed_in   = '0;
         status_in    = spq_pkg::ST_DONE;
         if (req_ch.req_type == spq_pkg::OP_INSERT) begin
            if (full) begin
               status_in = spq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CntW'(1);
            end
         end else begin
            if (empty) begin
               status_in = spq_pkg::ST_EMPTY;
            end else begin
               removed_in = links[0].value;
               count_in   = count_ff - CntW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.removed_value = removed_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.entry_count   = spq_pkg::CountW'(count_ff);

   // The count never grows past the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("entry count exceeds depth");

   // A successful remove shrinks the count by exactly one.
   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      cmd.rem |=> count_ff == $past(count_ff) - CntW'(1))
      else $error("remove did not decrement count");

   // A full refusal reports a full store, an empty refusal an empty one.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == spq_pkg::ST_FULL |-> count_ff == CntW'(DEPTH))
      else $error("full status with room left");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == spq_pkg::ST_EMPTY |-> count_ff == '0 && removed_ff == '0)
      else $error("empty status with entries stored");

   // The two lowest entries stay in ascending order.
   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CntW'(2) |-> links[0].value <= links[1].value)
      else $error("head of store out of order");

endmodule
